FILE: hw/rtl/ilt_pkg.sv
package ilt_pkg;

    // Default capacity and fixed field widths of the request and result channels.
    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 5;
    localparam int POS2_W           = 4;
    localparam int STATUS_W         = 2;
    localparam int FOUND_W          = 5;
    localparam int COUNT_W          = 5;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_READ   = 3'd3,
        REQ_WRITE  = 3'd4,
        REQ_FIND   = 3'd5,
        REQ_SWAP   = 3'd6,
        REQ_CLEAR  = 3'd7
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LOOP_CHK,
        S_SH_RD,
        S_SH_WR,
        S_FINAL,
        S_FIND_RD,
        S_FIND_CMP,
        S_RD_WAIT,
        S_SW_A,
        S_SW_B,
        S_SW_C,
        S_DONE
    } state_t;

    // Memory read address sources.
    typedef enum logic [1:0] {
        RA_POS,
        RA_POS2,
        RA_IDX,
        RA_IDX_M1
    } raddr_sel_t;

    // Memory write address sources.
    typedef enum logic [2:0] {
        WA_COUNT,
        WA_POS,
        WA_POS2,
        WA_IDX,
        WA_IDX_M1,
        WA_COUNT_M1
    } waddr_sel_t;

    // Memory write data sources.
    typedef enum logic [1:0] {
        WD_VALUE,
        WD_RDATA,
        WD_HOLD,
        WD_ZERO
    } wdata_sel_t;

    // Cursor updates.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS_P1,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    // Entry count updates.
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       req_load;
        logic       rd_en;
        raddr_sel_t rd_sel;
        logic       wr_en;
        waddr_sel_t wr_sel;
        wdata_sel_t wd_sel;
        idx_op_t    idx_op;
        cnt_op_t    cnt_op;
        logic       hold_load;
        logic       status_load;
        status_t    status_code;
        logic       rd_load_mem;
        logic       rd_load_ones;
        logic       found_load;
        logic       out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        req_t req_type;
        logic pos_gt_count;
        logic pos_ge_count;
        logic pos2_ge_count;
        logic full;
        logic idx_eq_pos;
        logic idx_eq_count;
        logic match;
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: hw/rtl/indexed_list_table_core.sv
// Channel   Handshake            Payload
// request   in_valid / in_ready  req_type, position, second_position, value
// result    out_valid/out_ready  status, read_value, found_index, element_count, is_empty
//
// One request is worked at a time; the list lives in a memory with one write
// port and one registered read port, used for one write and one read per cycle.
// Insert and remove take longer with each entry moved, and find with each entry
// checked before the match or the end of the list.
// Reset clears the count and the output valid flag; stored words are not cleared.
// A result waiting in the output register does not block work on the next request.

module indexed_list_table_core #(
    parameter int CAPACITY = ilt_pkg::DEFAULT_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           req_type,
    input  logic [ilt_pkg::POS_W-1:0]            position,
    input  logic [ilt_pkg::POS2_W-1:0]           second_position,
    input  logic signed [ilt_pkg::DATA_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ilt_pkg::STATUS_W-1:0]         status,
    output logic signed [ilt_pkg::DATA_W-1:0]    read_value,
    output logic signed [ilt_pkg::FOUND_W-1:0]   found_index,
    output logic [ilt_pkg::COUNT_W-1:0]          element_count,
    output logic                                 is_empty
);

    import ilt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ilt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ilt_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .position       (position),
        .second_position(second_position),
        .value          (value),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .read_value     (read_value),
        .found_index    (found_index),
        .element_count  (element_count),
        .is_empty       (is_empty)
    );

    // A full rejection only happens with the list at capacity.
    a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> element_count == COUNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    // A found position comes only with a successful status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found_index != {FOUND_W{1'b1}}) |-> status == ST_OK)
        else $error("found position without ok status");

    // The empty flag agrees with the count, checked only for capacities up to 31.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((CAPACITY > 31) || (is_empty == (element_count == '0))))
        else $error("empty flag disagrees with count");

    // A position error never reports a found position.
    a_range_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_RANGE) |-> found_index == {FOUND_W{1'b1}})
        else $error("range error with a found position");

endmodule

FILE: hw/rtl/ilt_ram.sv
module ilt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one read port; read data is registered and holds
    // until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/ilt_datapath.sv
module ilt_datapath #(
    parameter int CAPACITY = ilt_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ilt_pkg::dp_cmd_t              cmd,
    output ilt_pkg::dp_stat_t             stat,
    input  logic [2:0]                    req_type,
    input  logic [ilt_pkg::POS_W-1:0]     position,
    input  logic [ilt_pkg::POS2_W-1:0]    second_position,
    input  logic [ilt_pkg::DATA_W-1:0]    value,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ilt_pkg::STATUS_W-1:0]  status,
    output logic [ilt_pkg::DATA_W-1:0]    read_value,
    output logic [ilt_pkg::FOUND_W-1:0]   found_index,
    output logic [ilt_pkg::COUNT_W-1:0]   element_count,
    output logic                          is_empty
);

    import ilt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // Latched request.
    req_t                req_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS2_W-1:0]   pos2_reg;
    logic [DATA_W-1:0]   value_reg;

    // Cursor, count and swap holding register.
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [DATA_W-1:0]   hold_reg;

    // Working result and output register.
    status_t             res_status_reg;
    logic [DATA_W-1:0]   res_rd_reg;
    logic [FOUND_W-1:0]  res_found_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_rd_reg;
    logic [FOUND_W-1:0]  out_found_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_empty_reg;

    // Memory port signals.
    logic [AW-1:0]       ram_raddr;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    // Compare positions and cursor against the count at a common width.
    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       pos2_x;
    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       idx_x;

    assign pos_x  = XW'(pos_reg);
    assign pos2_x = XW'(pos2_reg);
    assign cnt_x  = XW'(count_reg);
    assign idx_x  = XW'(idx_reg);

    always_comb
    begin
        stat.req_type      = req_reg;
        stat.pos_gt_count  = pos_x > cnt_x;
        stat.pos_ge_count  = pos_x >= cnt_x;
        stat.pos2_ge_count = pos2_x >= cnt_x;
        stat.full          = count_reg == CW'(CAPACITY);
        stat.idx_eq_pos    = idx_x == pos_x;
        stat.idx_eq_count  = idx_reg == count_reg;
        stat.match         = ram_rdata == value_reg;
        stat.out_busy      = out_valid_reg && !out_ready;
    end

    // Memory address and data selection.
    always_comb
    begin
        case (cmd.rd_sel)
            RA_POS:    ram_raddr = AW'(pos_reg);
            RA_POS2:   ram_raddr = AW'(pos2_reg);
            RA_IDX:    ram_raddr = AW'(idx_reg);
            RA_IDX_M1: ram_raddr = AW'(idx_reg - CW'(1));
            default:   ram_raddr = AW'(idx_reg);
        endcase

        case (cmd.wr_sel)
            WA_COUNT:    ram_waddr = AW'(count_reg);
            WA_POS:      ram_waddr = AW'(pos_reg);
            WA_POS2:     ram_waddr = AW'(pos2_reg);
            WA_IDX:      ram_waddr = AW'(idx_reg);
            WA_IDX_M1:   ram_waddr = AW'(idx_reg - CW'(1));
            WA_COUNT_M1: ram_waddr = AW'(count_reg - CW'(1));
            default:     ram_waddr = AW'(count_reg);
        endcase

        case (cmd.wd_sel)
            WD_VALUE: ram_wdata = value_reg;
            WD_RDATA: ram_wdata = ram_rdata;
            WD_HOLD:  ram_wdata = hold_reg;
            WD_ZERO:  ram_wdata = '0;
            default:  ram_wdata = value_reg;
        endcase
    end

    ilt_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (cmd.wr_en),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (cmd.rd_en),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Cursor, count and output valid updates.
    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_COUNT:  idx_next = count_reg;
            IDX_POS_P1: idx_next = CW'(pos_reg) + CW'(1);
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + CW'(1);
            IDX_DEC:    idx_next = idx_reg - CW'(1);
            default:    idx_next = idx_reg;
        endcase

        case (cmd.cnt_op)
            CNT_HOLD:  count_next = count_reg;
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_reg - CW'(1);
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state: entry count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;

        if (cmd.req_load)
        begin
            req_reg        <= req_t'(req_type);
            pos_reg        <= position;
            pos2_reg       <= second_position;
            value_reg      <= value;
            res_status_reg <= ST_OK;
            res_rd_reg     <= '0;
            res_found_reg  <= '1;
        end
        else
        begin
            if (cmd.status_load)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.rd_load_mem)
            begin
                res_rd_reg <= ram_rdata;
            end
            else if (cmd.rd_load_ones)
            begin
                res_rd_reg <= '1;
            end
            if (cmd.found_load)
            begin
                res_found_reg <= FOUND_W'(idx_reg);
            end
        end

        if (cmd.hold_load)
        begin
            hold_reg <= ram_rdata;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_rd_reg     <= res_rd_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_empty_reg  <= count_reg == '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign read_value    = out_rd_reg;
    assign found_index   = out_found_reg;
    assign element_count = out_count_reg;
    assign is_empty      = out_empty_reg;

endmodule

FILE: hw/rtl/ilt_ctrl.sv
module ilt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ilt_pkg::dp_stat_t stat,
    output ilt_pkg::dp_cmd_t  cmd
);

    import ilt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   is_insert;

    assign is_insert = stat.req_type == REQ_INSERT;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_EXEC;
                end
            end

            // Check the request and start its work.
            S_EXEC:
            begin
                state_next = S_DONE;
                case (stat.req_type)
                    REQ_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WA_COUNT;
                            cmd.wd_sel = WD_VALUE;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (stat.pos_gt_count)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            state_next = S_LOOP_CHK;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS_P1;
                            state_next = S_LOOP_CHK;
                        end
                    end
                    REQ_READ:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            cmd.status_load  = 1'b1;
                            cmd.status_code  = ST_RANGE;
                            cmd.rd_load_ones = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_POS;
                            state_next = S_RD_WAIT;
                        end
                    end
                    REQ_WRITE:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = WA_POS;
                            cmd.wd_sel = WD_VALUE;
                        end
                    end
                    REQ_FIND:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_LOOP_CHK;
                    end
                    REQ_SWAP:
                    begin
                        if (stat.pos_ge_count || stat.pos2_ge_count)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_RANGE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_POS;
                            state_next = S_SW_A;
                        end
                    end
                    default:
                    begin
                        cmd.cnt_op = CNT_CLEAR;
                    end
                endcase
            end

            // Decide whether the shift or scan loop is finished.
            S_LOOP_CHK:
            begin
                case (stat.req_type)
                    REQ_INSERT:
                    begin
                        state_next = stat.idx_eq_pos ? S_FINAL : S_SH_RD;
                    end
                    REQ_REMOVE:
                    begin
                        state_next = stat.idx_eq_count ? S_FINAL : S_SH_RD;
                    end
                    default:
                    begin
                        if (stat.idx_eq_count)
                        begin
                            cmd.status_load = 1'b1;
                            cmd.status_code = ST_ABSENT;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                endcase
            end

            // Move one entry: up for insert, down for remove.
            S_SH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = is_insert ? RA_IDX_M1 : RA_IDX;
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wd_sel = WD_RDATA;
                cmd.wr_sel = is_insert ? WA_IDX : WA_IDX_M1;
                cmd.idx_op = is_insert ? IDX_DEC : IDX_INC;
                state_next = S_LOOP_CHK;
            end

            // Place the new value, or zero the slot vacated by a remove.
            S_FINAL:
            begin
                cmd.wr_en = 1'b1;
                if (is_insert)
                begin
                    cmd.wr_sel = WA_POS;
                    cmd.wd_sel = WD_VALUE;
                    cmd.cnt_op = CNT_INC;
                end
                else
                begin
                    cmd.wr_sel = WA_COUNT_M1;
                    cmd.wd_sel = WD_ZERO;
                    cmd.cnt_op = CNT_DEC;
                end
                state_next = S_DONE;
            end

            // Scan for the first matching entry.
            S_FIND_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_IDX;
                state_next = S_FIND_CMP;
            end

            S_FIND_CMP:
            begin
                if (stat.match)
                begin
                    cmd.found_load = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_LOOP_CHK;
                end
            end

            S_RD_WAIT:
            begin
                cmd.rd_load_mem = 1'b1;
                state_next      = S_DONE;
            end

            // Swap: hold the first entry, read the second, write both back.
            S_SW_A:
            begin
                cmd.hold_load = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RA_POS2;
                state_next    = S_SW_B;
            end

            S_SW_B:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_POS;
                cmd.wd_sel = WD_RDATA;
                state_next = S_SW_C;
            end

            S_SW_C:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_POS2;
                cmd.wd_sel = WD_HOLD;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ilt_pkg::*;

    localparam int LIST_DEPTH   = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        req_t                     kind;
        logic [POS_W-1:0]         pos;
        logic [POS2_W-1:0]        pos2;
        logic signed [DATA_W-1:0] val;
    } list_req_t;

    typedef struct {
        status_t                   status;
        logic signed [DATA_W-1:0]  rd;
        logic signed [FOUND_W-1:0] found;
        logic [COUNT_W-1:0]        count;
        logic                      empty;
    } list_result_t;

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_ready;
    req_t                       req_type        = REQ_APPEND;
    logic [POS_W-1:0]           position        = '0;
    logic [POS2_W-1:0]          second_position = '0;
    logic signed [DATA_W-1:0]   value           = '0;
    logic                       out_valid;
    logic                       out_ready       = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   read_value;
    logic signed [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]         element_count;
    logic                       is_empty;

    // Requests still to be offered, and the results they are expected to give.
    list_req_t    request_queue[$];
    list_result_t expected_results[$];

    // Shadow copy of the list contents.
    logic signed [DATA_W-1:0] model_words [LIST_DEPTH];
    int model_count = 0;

    int  total_items   = 0;
    int  sent_cnt      = 0;
    int  err_cnt       = 0;
    int  cycle_cnt     = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  stall_left    = 0;
    bit  hold_done     = 1'b0;

    indexed_list_table_core #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .position(position),
        .second_position(second_position),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .read_value(read_value),
        .found_index(found_index),
        .element_count(element_count),
        .is_empty(is_empty)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one request to the shadow list and return the result it must produce.
    function automatic list_result_t apply_request(list_req_t r);
        list_result_t res;
        int i;
        res.status = ST_OK;
        res.rd     = '0;
        res.found  = '1;
        case (r.kind)
            REQ_APPEND:
            begin
                if (model_count >= LIST_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    model_words[model_count] = r.val;
                    model_count++;
                end
            end
            REQ_INSERT:
            begin
                if (r.pos > model_count)
                begin
                    res.status = ST_RANGE;
                end
                else if (model_count >= LIST_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (i = model_count; i > r.pos; i--)
                        model_words[i] = model_words[i-1];
                    model_words[r.pos] = r.val;
                    model_count++;
                end
            end
            REQ_REMOVE:
            begin
                if (r.pos >= model_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    for (i = r.pos + 1; i < model_count; i++)
                        model_words[i-1] = model_words[i];
                    model_words[model_count-1] = '0;
                    model_count--;
                end
            end
            REQ_READ:
            begin
                if (r.pos >= model_count)
                begin
                    res.status = ST_RANGE;
                    res.rd     = '1;
                end
                else
                begin
                    res.rd = model_words[r.pos];
                end
            end
            REQ_WRITE:
            begin
                if (r.pos >= model_count)
                    res.status = ST_RANGE;
                else
                    model_words[r.pos] = r.val;
            end
            REQ_FIND:
            begin
                res.status = ST_ABSENT;
                for (i = 0; i < model_count; i++)
                begin
                    if (res.status == ST_ABSENT && model_words[i] == r.val)
                    begin
                        res.status = ST_OK;
                        res.found  = FOUND_W'(i);
                    end
                end
            end
            REQ_SWAP:
            begin
                if (r.pos >= model_count || r.pos2 >= model_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.rd             = model_words[r.pos];
                    model_words[r.pos] = model_words[r.pos2];
                    model_words[r.pos2] = res.rd;
                    res.rd             = '0;
                end
            end
            default:
            begin
                model_count = 0;
            end
        endcase
        res.count = COUNT_W'(model_count);
        res.empty = (model_count == 0);
        return res;
    endfunction

    task automatic queue_request(req_t kind, int pos, int pos2, logic signed [DATA_W-1:0] val);
        list_req_t r;
        r.kind = kind;
        r.pos  = POS_W'(pos);
        r.pos2 = POS2_W'(pos2);
        r.val  = val;
        request_queue.push_back(r);
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
            err_cnt++;
        end
    endtask

    // Idle rates by thirds of the run: sender light and receiver heavy, then swapped,
    // then no idling at all.
    always_comb
    begin
        if (sent_cnt < total_items / 3)
        begin
            send_idle_pct = 20;
            recv_idle_pct = 65;
        end
        else if (sent_cnt < 2 * total_items / 3)
        begin
            send_idle_pct = 65;
            recv_idle_pct = 20;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Request driver: a transfer is predicted when it happens, then the next item is offered.
    always @(posedge clk or negedge rst_n)
    begin : drive
        list_req_t next_req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(
                    apply_request('{req_type, position, second_position, value}));
                sent_cnt <= sent_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req        = request_queue.pop_front();
                    req_type        <= next_req.kind;
                    position        <= next_req.pos;
                    second_position <= next_req.pos2;
                    value           <= next_req.val;
                    in_valid        <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the result channel late in the run, so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            hold_done  <= 1'b0;
        end
        else if (!hold_done && total_items != 0 && sent_cnt >= total_items * 4 / 5)
        begin
            stall_left <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // Result receiver readiness.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: every transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d, read_value %0h, count %0d",
                         $time, status, read_value, element_count);
                err_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, status);
                check_field("read_value", want.rd, read_value);
                check_field("found_index", want.found, found_index);
                check_field("element_count", want.count, element_count);
                check_field("is_empty", want.empty, is_empty);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        list_req_t r;
        int bias;
        int grow_pct;
        int shrink_pct;
        int roll;

        // Directed part: empty-list rejections, extreme values, inserts at both ends
        // and past the end, reads and writes on either side of the count, find hit
        // and miss, swap in and out of range, removes, and clear.
        queue_request(REQ_READ,   0, 0, '0);
        queue_request(REQ_REMOVE, 0, 0, '0);
        queue_request(REQ_FIND,   0, 0, '0);
        queue_request(REQ_SWAP,   0, 0, '0);
        queue_request(REQ_WRITE,  0, 0, 32'sh1234_5678);
        queue_request(REQ_APPEND, 0, 0, 32'sh7FFF_FFFF);
        queue_request(REQ_APPEND, 0, 0, 32'sh8000_0000);
        queue_request(REQ_APPEND, 0, 0, -32'sd1);
        queue_request(REQ_INSERT, 0, 0, '0);
        queue_request(REQ_INSERT, 4, 0, 32'sd5);
        queue_request(REQ_INSERT, 16, 0, 32'sd9);
        queue_request(REQ_READ,   4, 0, '0);
        queue_request(REQ_READ,   5, 0, '0);
        queue_request(REQ_WRITE,  1, 0, 32'sh0F0F_0F0F);
        queue_request(REQ_FIND,   0, 0, 32'sh8000_0000);
        queue_request(REQ_FIND,   0, 0, 32'sd12345);
        queue_request(REQ_SWAP,   0, 4, '0);
        queue_request(REQ_SWAP,   1, 15, '0);
        queue_request(REQ_REMOVE, 2, 0, '0);
        queue_request(REQ_REMOVE, 3, 0, '0);
        queue_request(REQ_REMOVE, 4, 0, '0);
        queue_request(REQ_CLEAR,  0, 0, '0);
        queue_request(REQ_READ,   0, 0, '0);
        queue_request(REQ_APPEND, 0, 0, '0);

        // Random part: stretches that grow, hold or shrink the list, so it fills up
        // and drains repeatedly. Values come mostly from a small pool so finds hit.
        bias = 0;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 48 == 0)
                bias = $urandom_range(2);
            case (bias)
                0:
                begin
                    grow_pct   = 55;
                    shrink_pct = 10;
                end
                1:
                begin
                    grow_pct   = 25;
                    shrink_pct = 25;
                end
                default:
                begin
                    grow_pct   = 10;
                    shrink_pct = 45;
                end
            endcase
            roll = $urandom_range(99);
            if (roll >= 98)
                r.kind = REQ_CLEAR;
            else if (roll < grow_pct)
                r.kind = $urandom_range(1) ? REQ_INSERT : REQ_APPEND;
            else if (roll < grow_pct + shrink_pct)
                r.kind = REQ_REMOVE;
            else
                r.kind = req_t'($urandom_range(REQ_READ, REQ_SWAP));
            r.pos  = POS_W'($urandom_range(1) ? $urandom_range(16) : $urandom_range(4));
            r.pos2 = POS2_W'($urandom_range(1) ? $urandom_range(15) : $urandom_range(3));
            case ($urandom_range(9))
                0, 1, 2, 3, 4: r.val = $signed($urandom_range(7)) - 4;
                5:             r.val = 32'sh7FFF_FFFF;
                6:             r.val = 32'sh8000_0000;
                default:       r.val = $urandom;
            endcase
            request_queue.push_back(r);
        end
        total_items = request_queue.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every result to come back.
        while (sent_cnt != total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
